[hw/rtl/apw_pkg.sv]
package apw_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int MAX_POOL = 8;

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  // field and register widths
  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 6;
  localparam int DIM_W    = 7;
  localparam int POOL_W   = 4;
  localparam int STEP_W   = 4;
  localparam int PAD_W    = 3;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 3;

  // window coordinates: row * stride - pad spans -7 .. 945, signed
  localparam int PROD_W = POS_W + STEP_W;
  localparam int CO_W   = PROD_W + 2;
  // pool area up to 8 * 8 after clipping; the width holds 15 * 15
  localparam int AREA_W = 2 * POOL_W;
  localparam int SUM_W  = SAMPLE_W + ((MAX_POOL > 1) ? $clog2(MAX_POOL * MAX_POOL) : 0);
  localparam int CNT_W  = $clog2(SUM_W + 1);

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_HEIGHT   = 3'd0,
    CFG_IN_WIDTH    = 3'd1,
    CFG_POOL_HEIGHT = 3'd2,
    CFG_POOL_WIDTH  = 3'd3,
    CFG_STRIDE_ROWS = 3'd4,
    CFG_STRIDE_COLS = 3'd5,
    CFG_PAD_ROWS    = 3'd6,
    CFG_PAD_COLS    = 3'd7
  } cfg_index_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_READ,
    ST_DRAIN,
    ST_START,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load_win;
    logic step;
    logic div_start;
    logic out_load;
  } apw_cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
    logic div_done;
    logic out_free;
  } apw_status_t;

endpackage

[hw/rtl/average_pool_window.sv]
// Average pooling over one stored plane of signed Q8.8 samples.
// Input channel (in_valid_i/in_ready_o): op_i = write stores sample_i at
// (row_i, col_i), dropped when outside in_height x in_width; op_i = query
// names an output position and yields one beat on the output channel.
// Output channel (out_valid_o/out_ready_i) carries average_o: the window sum
// divided by pool_height * pool_width, each clipped to 8, truncated toward
// zero; padding counts toward the divisor and an empty window gives 0.
// A query closes the input side until its average is loaded: it sets up
// the window bounds, reads the clipped window (0..64 entries) with one
// plane-store read per cycle through the single read port, passes a drain
// state (skipped for an empty window), starts the bit-serial divider, waits
// for it to finish and then loads the output register.
// Configuration is written through cfg_we_i/cfg_index_i/cfg_data_i; the
// user must do so only while the block is idle; the block does not
// enforce it. Reset restores the register defaults (64 x 64 plane, 2 x 2
// pool, stride 2, no padding) and empties the output register; the plane
// contents are undefined until written.
// A finished average waits in the output register while the receiver stalls;
// the block keeps taking writes meanwhile, and a following query finishes
// its work and then waits until that register is free.
module average_pool_window import apw_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_W-1:0]           cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       op_i,
  input  logic [POS_W-1:0]           row_i,
  input  logic [POS_W-1:0]           col_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] average_o
);

  apw_cmd_t    cmd;
  apw_status_t status;
  state_e      state;
  logic        accept;

  assign accept = in_valid_i && in_ready_o;

  apw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .op_i      (op_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd),
    .state_o   (state)
  );

  apw_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .op_i       (op_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .sample_i   (sample_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .average_o  (average_o)
  );

  // a query closes the input side until its average is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == OP_QUERY) |=> !in_ready_o)
    else $error("input accepted while a query is in flight");

  // the divider never finishes in the cycle after its start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> !status.div_done)
    else $error("divider done too early");

  // reads only walk a non-empty window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> (!status.empty && state == ST_READ))
    else $error("store read outside a window walk");

  // a new average never overwrites one the receiver has not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !cmd.out_load)
    else $error("output register overwritten");

endmodule

[hw/rtl/apw_ram.sv]
module apw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[hw/rtl/apw_div.sv]
module apw_div import apw_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [SUM_W-1:0]    dividend_i,
  input  logic [AREA_W-1:0]          divisor_i,
  output logic                       done_o,
  output logic signed [SAMPLE_W-1:0] quotient_o
);

  logic [SUM_W-1:0]  mag_q, mag_d;
  logic [AREA_W:0]   rem_q, rem_d;
  logic [AREA_W-1:0] div_q;
  logic              neg_q, zero_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;

  logic [AREA_W:0]   rem_sh;
  logic              ge;
  logic [SUM_W-1:0]  mag_out;

  // restoring division on magnitudes, one quotient bit per cycle
  assign rem_sh = {rem_q[AREA_W-1:0], mag_q[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, div_q};

  always_comb begin
    mag_d  = mag_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      mag_d  = dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : SUM_W'(dividend_i);
      rem_d  = '0;
      cnt_d  = CNT_W'(SUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      mag_d = {mag_q[SUM_W-2:0], ge};
      rem_d = ge ? rem_sh - {1'b0, div_q} : rem_sh;
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    if (start_i) begin
      div_q  <= divisor_i;
      neg_q  <= dividend_i[SUM_W-1];
      zero_q <= (divisor_i == '0);
    end
  end

  assign mag_out    = neg_q ? (~mag_q + SUM_W'(1)) : mag_q;
  assign quotient_o = zero_q ? '0 : $signed(mag_out[SAMPLE_W-1:0]);
  assign done_o     = done_q;

endmodule

[hw/rtl/apw_datapath.sv]
module apw_datapath import apw_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_W-1:0]           cfg_data_i,
  input  logic                       accept_i,
  input  logic                       op_i,
  input  logic [POS_W-1:0]           row_i,
  input  logic [POS_W-1:0]           col_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  apw_cmd_t                   cmd_i,
  output apw_status_t                status_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic signed [SAMPLE_W-1:0] average_o
);

  logic [DIM_W-1:0]    in_height_q, in_width_q;
  logic [POOL_W-1:0]   pool_height_q, pool_width_q;
  logic [STEP_W-1:0]   stride_rows_q, stride_cols_q;
  logic [PAD_W-1:0]    pad_rows_q, pad_cols_q;

  logic [POS_W-1:0] r_q, c_q;
  logic [DIM_W-1:0] eh, ew;
  logic [POOL_W-1:0] ph, pw;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_height_q   <= DIM_W'(64);
      in_width_q    <= DIM_W'(64);
      pool_height_q <= POOL_W'(2);
      pool_width_q  <= POOL_W'(2);
      stride_rows_q <= STEP_W'(2);
      stride_cols_q <= STEP_W'(2);
      pad_rows_q    <= '0;
      pad_cols_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_IN_HEIGHT:   in_height_q   <= cfg_data_i;
        CFG_IN_WIDTH:    in_width_q    <= cfg_data_i;
        CFG_POOL_HEIGHT: pool_height_q <= cfg_data_i[POOL_W-1:0];
        CFG_POOL_WIDTH:  pool_width_q  <= cfg_data_i[POOL_W-1:0];
        CFG_STRIDE_ROWS: stride_rows_q <= cfg_data_i[STEP_W-1:0];
        CFG_STRIDE_COLS: stride_cols_q <= cfg_data_i[STEP_W-1:0];
        CFG_PAD_ROWS:    pad_rows_q    <= cfg_data_i[PAD_W-1:0];
        CFG_PAD_COLS:    pad_cols_q    <= cfg_data_i[PAD_W-1:0];
      endcase
    end
  end

  // effective sizes, clipped to the store and the largest pool
  assign eh = (int'(in_height_q) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : in_height_q;
  assign ew = (int'(in_width_q) > MAX_COLS) ? DIM_W'(MAX_COLS) : in_width_q;
  assign ph = (int'(pool_height_q) > MAX_POOL) ? POOL_W'(MAX_POOL) : pool_height_q;
  assign pw = (int'(pool_width_q) > MAX_POOL) ? POOL_W'(MAX_POOL) : pool_width_q;

  always_ff @(posedge clk_i) begin
    if (accept_i && op_i == OP_QUERY) begin
      r_q <= row_i;
      c_q <= col_i;
    end
  end

  // window bounds, clipped to the plane
  logic [PROD_W-1:0]    prod_r, prod_c;
  logic signed [CO_W-1:0] hs, ws, hend, wend, h0s, w0s, h1s, w1s, eh_s, ew_s;

  assign prod_r = PROD_W'(r_q) * PROD_W'(stride_rows_q);
  assign prod_c = PROD_W'(c_q) * PROD_W'(stride_cols_q);
  assign hs   = $signed({2'b00, prod_r}) - $signed(CO_W'(pad_rows_q));
  assign ws   = $signed({2'b00, prod_c}) - $signed(CO_W'(pad_cols_q));
  assign hend = hs + $signed(CO_W'(ph));
  assign wend = ws + $signed(CO_W'(pw));
  assign eh_s = $signed(CO_W'(eh));
  assign ew_s = $signed(CO_W'(ew));
  assign h0s  = hs[CO_W-1] ? '0 : hs;
  assign w0s  = ws[CO_W-1] ? '0 : ws;
  assign h1s  = (hend < eh_s) ? hend : eh_s;
  assign w1s  = (wend < ew_s) ? wend : ew_s;

  logic [DIM_W-1:0] h1_q, w0_q, w1_q, ih_q, iw_q;
  logic [DIM_W-1:0] ih_nx, iw_nx;

  assign ih_nx = ih_q + DIM_W'(1);
  assign iw_nx = iw_q + DIM_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_win) begin
      ih_q <= h0s[DIM_W-1:0];
      iw_q <= w0s[DIM_W-1:0];
      w0_q <= w0s[DIM_W-1:0];
      h1_q <= h1s[DIM_W-1:0];
      w1_q <= w1s[DIM_W-1:0];
    end else if (cmd_i.step) begin
      if (iw_nx == w1_q) begin
        iw_q <= w0_q;
        ih_q <= ih_nx;
      end else begin
        iw_q <= iw_nx;
      end
    end
  end

  // plane store
  logic              wr_en;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [SAMPLE_W-1:0] rdata;

  assign wr_en = accept_i && (op_i == OP_WRITE)
              && ({1'b0, row_i} < eh) && ({1'b0, col_i} < ew);
  assign waddr = ADDR_W'(ADDR_W'(row_i) * ADDR_W'(MAX_COLS) + ADDR_W'(col_i));
  assign raddr = ADDR_W'(ADDR_W'(ih_q[ROW_W-1:0]) * ADDR_W'(MAX_COLS)
                 + ADDR_W'(iw_q[COL_W-1:0]));

  apw_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(waddr),
    .wdata_i(sample_i),
    .re_i   (cmd_i.step),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // accumulate each read word, qualified by the registered read strobe
  logic                    rd_vld_q;
  logic signed [SUM_W-1:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_win) begin
      sum_q <= '0;
    end else if (rd_vld_q) begin
      sum_q <= sum_q + SUM_W'($signed(rdata));
    end
  end

  logic                       div_done;
  logic signed [SAMPLE_W-1:0] quotient;
  logic [AREA_W-1:0]          area;

  assign area = AREA_W'(ph) * AREA_W'(pw);

  apw_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(sum_q),
    .divisor_i (area),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      average_o <= quotient;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.empty    = (h1s <= h0s) || (w1s <= w0s);
  assign status_o.last     = (iw_nx == w1_q) && (ih_nx == h1_q);
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

[hw/rtl/apw_ctrl.sv]
module apw_ctrl import apw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        op_i,
  output logic        in_ready_o,
  input  apw_status_t status_i,
  output apw_cmd_t    cmd_o,
  output state_e      state_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && op_i == OP_QUERY) state_d = ST_SETUP;
      end
      ST_SETUP: state_d = status_i.empty ? ST_START : ST_READ;
      ST_READ: begin
        if (status_i.last) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV: begin
        if (status_i.div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_SETUP: cmd_o.load_win = 1'b1;
      ST_READ:  cmd_o.step = 1'b1;
      ST_DRAIN: ;
      ST_START: cmd_o.div_start = 1'b1;
      ST_DIV:   ;
      ST_OUT:   cmd_o.out_load = status_i.out_free;
      default:  ;
    endcase
  end

  assign state_o = state_q;

endmodule

[test/tb_average_pool_window.sv]
module tb_average_pool_window;
  import apw_pkg::*;

  localparam int PHASE_ITEMS  = 115;
  localparam int SETTLE_TICKS = 100;
  localparam int TIMEOUT      = 15_000_000;

  typedef struct packed {
    op_e                        op;
    logic [POS_W-1:0]           row;
    logic [POS_W-1:0]           col;
    logic signed [SAMPLE_W-1:0] sample;
  } pool_item_t;

  typedef struct {
    logic [DIM_W-1:0]    in_height;
    logic [DIM_W-1:0]    in_width;
    logic [POOL_W-1:0]   pool_height;
    logic [POOL_W-1:0]   pool_width;
    logic [STEP_W-1:0]   stride_rows;
    logic [STEP_W-1:0]   stride_cols;
    logic [PAD_W-1:0]    pad_rows;
    logic [PAD_W-1:0]    pad_cols;
  } pool_cfg_t;

  logic                       clk_i;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index_i = CFG_IN_HEIGHT;
  logic [CFG_W-1:0]           cfg_data_i  = '0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_ready_o;
  logic                       op_i        = OP_WRITE;
  logic [POS_W-1:0]           row_i       = '0;
  logic [POS_W-1:0]           col_i       = '0;
  logic signed [SAMPLE_W-1:0] sample_i    = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [SAMPLE_W-1:0] average_o;

  average_pool_window dut (.*);

  pool_cfg_t                  cfg;
  logic signed [SAMPLE_W-1:0] plane_copy [MAX_ROWS][MAX_COLS];
  bit                         plane_written [MAX_ROWS][MAX_COLS];
  pool_item_t                 pending_items [$];
  logic signed [SAMPLE_W-1:0] avg_expected [$];
  logic signed [SAMPLE_W-1:0] avg_head;
  pool_item_t                 cur_item;
  bit                         in_busy;
  bit                         idle_on;
  int                         in_gap;
  int                         out_stall;
  int                         stim_count;
  int                         fail_count;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT);
    $display("simulation failed");
    $finish;
  end

  function automatic int plane_rows();
    return (cfg.in_height > MAX_ROWS) ? MAX_ROWS : int'(cfg.in_height);
  endfunction

  function automatic int plane_cols();
    return (cfg.in_width > MAX_COLS) ? MAX_COLS : int'(cfg.in_width);
  endfunction

  function automatic int pool_rows();
    return (cfg.pool_height > MAX_POOL) ? MAX_POOL : int'(cfg.pool_height);
  endfunction

  function automatic int pool_cols();
    return (cfg.pool_width > MAX_POOL) ? MAX_POOL : int'(cfg.pool_width);
  endfunction

  // window clipped to the plane, half-open [h0,h1) x [w0,w1)
  function automatic void window_bounds(input int r, input int c,
                                        output int h0, output int h1,
                                        output int w0, output int w1);
    int hs, ws;
    hs = r * int'(cfg.stride_rows) - int'(cfg.pad_rows);
    ws = c * int'(cfg.stride_cols) - int'(cfg.pad_cols);
    h0 = (hs > 0) ? hs : 0;
    w0 = (ws > 0) ? ws : 0;
    h1 = (hs + pool_rows() < plane_rows()) ? hs + pool_rows() : plane_rows();
    w1 = (ws + pool_cols() < plane_cols()) ? ws + pool_cols() : plane_cols();
  endfunction

  // predictor: runs on every accepted input beat
  function automatic void apply_item(input pool_item_t it);
    int h0, h1, w0, w1, area, sum;
    if (it.op == OP_WRITE) begin
      if (int'(it.row) < plane_rows() && int'(it.col) < plane_cols())
        plane_copy[it.row][it.col] = it.sample;
    end else begin
      window_bounds(it.row, it.col, h0, h1, w0, w1);
      sum = 0;
      for (int i = h0; i < h1; i++)
        for (int j = w0; j < w1; j++)
          sum += plane_copy[i][j];
      area = pool_rows() * pool_cols();
      avg_expected.push_back((area == 0) ? '0 : SAMPLE_W'(sum / area));
    end
  endfunction

  function automatic void note_mismatch(input string what,
                                        input logic signed [SAMPLE_W-1:0] want,
                                        input logic signed [SAMPLE_W-1:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("%s: expected %0d, got %0d", what, want, got);
  endfunction

  // a query may only cover entries that have been written
  function automatic bit window_ready(input int r, input int c);
    int h0, h1, w0, w1;
    window_bounds(r, c, h0, h1, w0, w1);
    for (int i = h0; i < h1; i++)
      for (int j = w0; j < w1; j++)
        if (!plane_written[i][j]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void queue_write(input int r, input int c,
                                      input logic [SAMPLE_W-1:0] s);
    pool_item_t it;
    it.op     = OP_WRITE;
    it.row    = POS_W'(r);
    it.col    = POS_W'(c);
    it.sample = s;
    pending_items.push_back(it);
    if (r < plane_rows() && c < plane_cols()) begin
      plane_written[r][c] = 1'b1;
      stim_count++;
    end
  endfunction

  function automatic void queue_query(input int r, input int c);
    pool_item_t it;
    it.op     = OP_QUERY;
    it.row    = POS_W'(r);
    it.col    = POS_W'(c);
    it.sample = SAMPLE_W'($urandom);
    pending_items.push_back(it);
    stim_count++;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // output position whose window mostly lands on the plane
  function automatic int pick_pos(input int stride, input int pad, input int span);
    int hi;
    if (stride == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, 63);
    hi = (span + pad) / stride;
    return $urandom_range(0, (hi > 63) ? 63 : hi);
  endfunction

  // mostly legal, now and then anything the register holds
  function automatic int pick_reg(input int lo, input int hi, input int top);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, top) : $urandom_range(lo, hi);
  endfunction

  task automatic set_reg(input cfg_index_e idx, input int val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_W'(val);
    case (idx)
      CFG_IN_HEIGHT:   cfg.in_height   = DIM_W'(val);
      CFG_IN_WIDTH:    cfg.in_width    = DIM_W'(val);
      CFG_POOL_HEIGHT: cfg.pool_height = POOL_W'(val);
      CFG_POOL_WIDTH:  cfg.pool_width  = POOL_W'(val);
      CFG_STRIDE_ROWS: cfg.stride_rows = STEP_W'(val);
      CFG_STRIDE_COLS: cfg.stride_cols = STEP_W'(val);
      CFG_PAD_ROWS:    cfg.pad_rows    = PAD_W'(val);
      CFG_PAD_COLS:    cfg.pad_cols    = PAD_W'(val);
      default: ;
    endcase
  endtask

  task automatic configure(input int h, input int w, input int ph, input int pw,
                           input int sr, input int sc, input int pr, input int pc);
    set_reg(CFG_IN_HEIGHT, h);
    set_reg(CFG_IN_WIDTH, w);
    set_reg(CFG_POOL_HEIGHT, ph);
    set_reg(CFG_POOL_WIDTH, pw);
    set_reg(CFG_STRIDE_ROWS, sr);
    set_reg(CFG_STRIDE_COLS, sc);
    set_reg(CFG_PAD_ROWS, pr);
    set_reg(CFG_PAD_COLS, pc);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure_random();
    configure(pick_reg(1, ($urandom_range(0, 2) == 0) ? 64 : 16, 127),
              pick_reg(1, ($urandom_range(0, 2) == 0) ? 64 : 16, 127),
              pick_reg(1, 8, 15), pick_reg(1, 8, 15),
              pick_reg(1, 8, 15), pick_reg(1, 8, 15),
              $urandom_range(0, 7), $urandom_range(0, 7));
  endtask

  // lets queued items and pending averages finish before the next register write
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_busy || avg_expected.size() != 0);
    repeat (SETTLE_TICKS) @(negedge clk_i);
  endtask

  task automatic run_phase(input int quota);
    int r, c, h0, h1, w0, w1, kind;
    stim_count = 0;
    @(negedge clk_i);
    while (stim_count < quota) begin
      kind = $urandom_range(0, 9);
      r = pick_pos(cfg.stride_rows, cfg.pad_rows, plane_rows());
      c = pick_pos(cfg.stride_cols, cfg.pad_cols, plane_cols());
      if (kind < 6) begin
        // fill the window (plus some rewrites), query it and, if ready, the next column
        window_bounds(r, c, h0, h1, w0, w1);
        for (int i = h0; i < h1; i++)
          for (int j = w0; j < w1; j++)
            if (!plane_written[i][j] || $urandom_range(0, 3) == 0)
              queue_write(i, j, rand_sample());
        queue_query(r, c);
        if (c < 63 && window_ready(r, c + 1)) queue_query(r, c + 1);
      end else if (kind < 8) begin
        queue_write($urandom_range(0, 63), $urandom_range(0, 63), rand_sample());
      end else if (window_ready(r, c)) begin
        queue_query(r, c);
      end
    end
    wait_idle();
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_busy = 1'b0;
      in_gap  = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        apply_item(cur_item);
        in_busy = 1'b0;
        if (idle_on && $urandom_range(0, 11) == 0) in_gap = $urandom_range(1, 19);
      end
      if (!in_busy) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_items.size() != 0) begin
          cur_item = pending_items.pop_front();
          op_i     <= cur_item.op;
          row_i    <= cur_item.row;
          col_i    <= cur_item.col;
          sample_i <= cur_item.sample;
          in_busy = 1'b1;
        end
      end
      in_valid_i <= in_busy;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (avg_expected.size() == 0) begin
          note_mismatch("average beat with none pending", 'x, average_o);
        end else begin
          avg_head = avg_expected.pop_front();
          if (average_o !== avg_head) note_mismatch("average mismatch", avg_head, average_o);
        end
      end
      if (out_stall > 0) out_stall--;
      else if (idle_on && $urandom_range(0, 11) == 0) out_stall = $urandom_range(1, 19);
      out_ready_i <= (out_stall == 0);
    end
  end

  initial begin
    cfg.in_height   = 64;
    cfg.in_width    = 64;
    cfg.pool_height = 2;
    cfg.pool_width  = 2;
    cfg.stride_rows = 2;
    cfg.stride_cols = 2;
    cfg.pad_rows    = 0;
    cfg.pad_cols    = 0;
    idle_on    = 1'b1;
    fail_count = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: negative and positive truncation, full-scale, empty windows
    @(negedge clk_i);
    queue_write(0, 0, 16'h8000);
    queue_write(0, 1, 16'h8000);
    queue_write(1, 0, 16'h8000);
    queue_write(1, 1, 16'h0001);
    queue_query(0, 0);
    queue_write(62, 62, 16'h7fff);
    queue_write(62, 63, 16'h7fff);
    queue_write(63, 62, 16'h7fff);
    queue_write(63, 63, 16'h7fff);
    queue_query(31, 31);
    queue_write(0, 0, 16'h7fff);
    queue_write(0, 1, 16'h7fff);
    queue_write(1, 0, 16'h7fff);
    queue_write(1, 1, 16'h7ffe);
    queue_query(0, 0);
    queue_query(63, 63);
    queue_query(0, 63);
    queue_query(63, 0);
    wait_idle();

    configure(1, 1, 1, 1, 1, 1, 0, 0);
    run_phase(PHASE_ITEMS);
    configure(64, 64, 8, 8, 8, 8, 7, 7);
    run_phase(PHASE_ITEMS);
    configure(0, 5, 3, 3, 1, 1, 1, 1);          // zero plane height
    run_phase(PHASE_ITEMS);
    configure(127, 100, 15, 9, 0, 0, 7, 3);     // oversize plane and pool, zero stride
    run_phase(PHASE_ITEMS);
    configure(6, 6, 0, 3, 1, 1, 2, 2);          // zero pool height
    run_phase(PHASE_ITEMS);
    repeat (8) begin
      configure_random();
      run_phase(PHASE_ITEMS);
    end
    idle_on = 1'b0;
    configure_random();
    run_phase(PHASE_ITEMS);

    if (fail_count == 0 && avg_expected.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/apw_pkg.sv
hw/rtl/apw_ram.sv
hw/rtl/apw_div.sv
hw/rtl/apw_datapath.sv
hw/rtl/apw_ctrl.sv
hw/rtl/average_pool_window.sv
test/tb_average_pool_window.sv
